@@ design/sia_pkg.sv @@
// Shared types and constants for the segment ID allocator memory.
// Used by sia_ctrl, sia_datapath, segment_id_allocator_memory and sia_checker.
// Depends on nothing.
`default_nettype none

package sia_pkg;

    typedef enum logic [2:0] {
        CMD_MAP        = 3'd0,
        CMD_UNMAP      = 3'd1,
        CMD_LOAD       = 3'd2,
        CMD_STORE      = 3'd3,
        CMD_LOAD_PROG  = 3'd4,
        CMD_PROG_ALLOC = 3'd5,
        CMD_PROG_WRITE = 3'd6,
        CMD_PROG_READ  = 3'd7
    } cmd_e;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_UNMAPPED = 3'd2,
        ST_RANGE    = 3'd3,
        ST_TOO_LONG = 3'd4
    } status_e;

    typedef struct packed {
        logic [2:0]  command;
        logic [5:0]  segment_id;
        logic [7:0]  word_offset;
        logic [8:0]  seg_length;
        logic [31:0] write_word;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  granted_id;
        logic [31:0] read_word;
        logic [8:0]  program_length;
    } rsp_t;

    typedef struct packed {
        logic       used;
        logic [8:0] len;
    } slot_ent_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_FILL,
        S_PFILL,
        S_COPY_RD,
        S_COPY_WR,
        S_RESP
    } state_e;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       ctr_clr;
        logic       ctr_inc;
        logic       slot_clr;
        logic       slot_map;
        logic       slot_unmap;
        logic       push;
        logic       pop;
        logic       seg_fill_wr;
        logic       seg_store_wr;
        logic       copy_mode;
        logic       prog_fill_wr;
        logic       prog_store_wr;
        logic       prog_copy_wr;
        logic       plen_from_len;
        logic       plen_from_slot;
        logic       res_load;
        logic [2:0] res_status;
        logic       res_grant;
        logic       res_seg;
        logic       res_prog;
        logic       out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] command;
        logic       id_live;
        logic       off_in_seg;
        logic       off_in_prog;
        logic       full;
        logic       too_long;
        logic       len_zero;
        logic       slen_zero;
        logic       ctr_last_len;
        logic       ctr_last_slen;
        logic       ctr_last_slot;
        logic       out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ design/sia_ctrl.sv @@
// Controller state machine of the segment ID allocator memory.
// Depends on sia_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module sia_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire sia_pkg::dp_stat_t stat,
    output sia_pkg::dp_cmd_t       ctl
);

    sia_pkg::state_e state_reg;
    sia_pkg::state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sia_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        cmd_ready  = 1'b0;
        case (state_reg)
            sia_pkg::S_CLEAR:
            begin
                ctl.slot_clr = 1'b1;
                ctl.ctr_inc  = 1'b1;
                if (stat.ctr_last_slot)
                begin
                    ctl.ctr_clr = 1'b1;
                    state_next  = sia_pkg::S_IDLE;
                end
            end
            sia_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = sia_pkg::S_LOOKUP;
                end
            end
            sia_pkg::S_LOOKUP:
            begin
                state_next = sia_pkg::S_EXEC;
            end
            sia_pkg::S_EXEC:
            begin
                ctl.res_load   = 1'b1;
                ctl.res_status = sia_pkg::ST_OK;
                ctl.ctr_clr    = 1'b1;
                state_next     = sia_pkg::S_RESP;
                case (stat.command)
                    sia_pkg::CMD_MAP:
                    begin
                        if (stat.full)
                        begin
                            ctl.res_status = sia_pkg::ST_FULL;
                        end
                        else if (stat.too_long)
                        begin
                            ctl.res_status = sia_pkg::ST_TOO_LONG;
                        end
                        else
                        begin
                            ctl.res_grant = 1'b1;
                            ctl.pop       = 1'b1;
                            ctl.slot_map  = 1'b1;
                            if (!stat.len_zero)
                            begin
                                state_next = sia_pkg::S_FILL;
                            end
                        end
                    end
                    sia_pkg::CMD_UNMAP:
                    begin
                        if (!stat.id_live)
                        begin
                            ctl.res_status = sia_pkg::ST_UNMAPPED;
                        end
                        else
                        begin
                            ctl.slot_unmap = 1'b1;
                            ctl.push       = 1'b1;
                        end
                    end
                    sia_pkg::CMD_LOAD, sia_pkg::CMD_STORE:
                    begin
                        if (!stat.id_live)
                        begin
                            ctl.res_status = sia_pkg::ST_UNMAPPED;
                        end
                        else if (!stat.off_in_seg)
                        begin
                            ctl.res_status = sia_pkg::ST_RANGE;
                        end
                        else if (stat.command == sia_pkg::CMD_LOAD)
                        begin
                            ctl.res_seg = 1'b1;
                        end
                        else
                        begin
                            ctl.seg_store_wr = 1'b1;
                        end
                    end
                    sia_pkg::CMD_LOAD_PROG:
                    begin
                        if (!stat.id_live)
                        begin
                            ctl.res_status = sia_pkg::ST_UNMAPPED;
                        end
                        else
                        begin
                            ctl.plen_from_slot = 1'b1;
                            if (!stat.slen_zero)
                            begin
                                state_next = sia_pkg::S_COPY_RD;
                            end
                        end
                    end
                    sia_pkg::CMD_PROG_ALLOC:
                    begin
                        if (stat.too_long)
                        begin
                            ctl.res_status = sia_pkg::ST_TOO_LONG;
                        end
                        else
                        begin
                            ctl.plen_from_len = 1'b1;
                            if (!stat.len_zero)
                            begin
                                state_next = sia_pkg::S_PFILL;
                            end
                        end
                    end
                    sia_pkg::CMD_PROG_WRITE:
                    begin
                        if (!stat.off_in_prog)
                        begin
                            ctl.res_status = sia_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ctl.prog_store_wr = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!stat.off_in_prog)
                        begin
                            ctl.res_status = sia_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ctl.res_prog = 1'b1;
                        end
                    end
                endcase
            end
            sia_pkg::S_FILL:
            begin
                ctl.seg_fill_wr = 1'b1;
                ctl.ctr_inc     = 1'b1;
                if (stat.ctr_last_len)
                begin
                    state_next = sia_pkg::S_RESP;
                end
            end
            sia_pkg::S_PFILL:
            begin
                ctl.prog_fill_wr = 1'b1;
                ctl.ctr_inc      = 1'b1;
                if (stat.ctr_last_len)
                begin
                    state_next = sia_pkg::S_RESP;
                end
            end
            sia_pkg::S_COPY_RD:
            begin
                ctl.copy_mode = 1'b1;
                state_next    = sia_pkg::S_COPY_WR;
            end
            sia_pkg::S_COPY_WR:
            begin
                ctl.copy_mode    = 1'b1;
                ctl.prog_copy_wr = 1'b1;
                ctl.ctr_inc      = 1'b1;
                if (stat.ctr_last_slen)
                begin
                    state_next = sia_pkg::S_RESP;
                end
                else
                begin
                    state_next = sia_pkg::S_COPY_RD;
                end
            end
            sia_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = sia_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sia_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/sia_datapath.sv @@
// Datapath of the segment ID allocator memory: request and result registers,
// slot table, free ID stack, segment store and program store. Depends on sia_pkg.
`default_nettype none

module sia_datapath #(
    parameter int SEGMENT_SLOTS = 64,
    parameter int SEGMENT_WORDS = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sia_pkg::req_t     cmd_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output sia_pkg::rsp_t          rsp_data,
    input  wire sia_pkg::dp_cmd_t  ctl,
    output sia_pkg::dp_stat_t      stat
);

    localparam int SLOT_W    = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
    localparam int CNT_W     = $clog2(SEGMENT_SLOTS + 1);
    localparam int WORD_W    = (SEGMENT_WORDS > 1) ? $clog2(SEGMENT_WORDS) : 1;
    localparam int SEG_DEPTH = SEGMENT_SLOTS * SEGMENT_WORDS;
    localparam int SEG_AW    = $clog2(SEG_DEPTH);
    localparam int CTR_W     = (CNT_W > 9) ? CNT_W : 9;

    sia_pkg::req_t     req_reg;
    logic [CTR_W-1:0]  ctr_reg;
    logic [CNT_W-1:0]  live_reg;
    logic [CNT_W-1:0]  fcount_reg;
    logic [SLOT_W-1:0] nid_reg;
    logic [8:0]        plen_reg;
    logic [2:0]        res_status_reg;
    logic [5:0]        res_granted_reg;
    logic [31:0]       res_read_reg;
    logic              out_valid_reg;
    sia_pkg::rsp_t     out_reg;

    sia_pkg::slot_ent_t slot_mem [SEGMENT_SLOTS];
    sia_pkg::slot_ent_t slot_rd_reg;
    logic [SLOT_W-1:0]  stack_mem [SEGMENT_SLOTS];
    logic [SLOT_W-1:0]  stack_rd_reg;
    logic [31:0]        seg_mem [SEG_DEPTH];
    logic [31:0]        seg_rd_reg;
    logic [31:0]        prog_mem [SEGMENT_WORDS];
    logic [31:0]        prog_rd_reg;

    logic [31:0]        id32;
    logic [31:0]        ctr32;
    logic [31:0]        off32;
    logic [SLOT_W-1:0]  req_slot;
    logic [SLOT_W-1:0]  nid_now;
    logic [31:0]        pop_addr32;
    logic [SLOT_W-1:0]  slot_waddr;
    sia_pkg::slot_ent_t slot_wdata;
    logic               slot_we;
    logic [31:0]        seg_ra32;
    logic [31:0]        seg_wa32;
    logic [31:0]        seg_wdata;
    logic               seg_we;
    logic [31:0]        prog_ra32;
    logic [31:0]        prog_wa32;
    logic [31:0]        prog_wdata;
    logic               prog_we;
    logic [CTR_W:0]     ctr_plus;

    assign id32       = 32'(req_reg.segment_id);
    assign ctr32      = 32'(ctr_reg);
    assign off32      = 32'(req_reg.word_offset);
    assign req_slot   = id32[SLOT_W-1:0];
    assign pop_addr32 = 32'(fcount_reg) - 32'd1;
    assign nid_now    = (fcount_reg == '0) ? live_reg[SLOT_W-1:0] : stack_rd_reg;
    assign ctr_plus   = {1'b0, ctr_reg} + 1'b1;

    // Slot table: cleared by a sweep after reset, then at most one write per command.
    always_comb
    begin
        slot_we    = ctl.slot_clr | ctl.slot_map | ctl.slot_unmap;
        slot_waddr = req_slot;
        slot_wdata = '0;
        if (ctl.slot_clr)
        begin
            slot_waddr = ctr_reg[SLOT_W-1:0];
        end
        else if (ctl.slot_map)
        begin
            slot_waddr      = nid_now;
            slot_wdata.used = 1'b1;
            slot_wdata.len  = req_reg.seg_length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[req_slot];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            stack_mem[fcount_reg[SLOT_W-1:0]] <= req_slot;
        end
        stack_rd_reg <= stack_mem[pop_addr32[SLOT_W-1:0]];
    end

    // Segment store addressing: slot base plus word index.
    always_comb
    begin
        seg_ra32 = id32 * 32'(SEGMENT_WORDS) + (ctl.copy_mode ? ctr32 : off32);
        seg_we   = ctl.seg_fill_wr | ctl.seg_store_wr;
        if (ctl.seg_fill_wr)
        begin
            seg_wa32  = 32'(nid_reg) * 32'(SEGMENT_WORDS) + ctr32;
            seg_wdata = '0;
        end
        else
        begin
            seg_wa32  = id32 * 32'(SEGMENT_WORDS) + off32;
            seg_wdata = req_reg.write_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[seg_wa32[SEG_AW-1:0]] <= seg_wdata;
        end
        seg_rd_reg <= seg_mem[seg_ra32[SEG_AW-1:0]];
    end

    always_comb
    begin
        prog_ra32  = off32;
        prog_we    = ctl.prog_fill_wr | ctl.prog_store_wr | ctl.prog_copy_wr;
        prog_wa32  = ctr32;
        prog_wdata = '0;
        if (ctl.prog_store_wr)
        begin
            prog_wa32  = off32;
            prog_wdata = req_reg.write_word;
        end
        else if (ctl.prog_copy_wr)
        begin
            prog_wdata = seg_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[prog_wa32[WORD_W-1:0]] <= prog_wdata;
        end
        prog_rd_reg <= prog_mem[prog_ra32[WORD_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            req_reg <= cmd_data;
        end
        if (ctl.pop)
        begin
            nid_reg <= nid_now;
        end
        if (ctl.res_load)
        begin
            res_status_reg  <= ctl.res_status;
            res_granted_reg <= ctl.res_grant ? 6'(nid_now) : 6'd0;
            res_read_reg    <= ctl.res_seg  ? seg_rd_reg  :
                               ctl.res_prog ? prog_rd_reg : 32'd0;
        end
        if (ctl.out_load)
        begin
            out_reg.status         <= res_status_reg;
            out_reg.granted_id     <= res_granted_reg;
            out_reg.read_word      <= res_read_reg;
            out_reg.program_length <= plen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg       <= '0;
            live_reg      <= '0;
            fcount_reg    <= '0;
            plen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.ctr_clr)
            begin
                ctr_reg <= '0;
            end
            else if (ctl.ctr_inc)
            begin
                ctr_reg <= ctr_plus[CTR_W-1:0];
            end
            if (ctl.pop)
            begin
                live_reg <= live_reg + 1'b1;
                if (fcount_reg != '0)
                begin
                    fcount_reg <= fcount_reg - 1'b1;
                end
            end
            else if (ctl.push)
            begin
                live_reg   <= live_reg - 1'b1;
                fcount_reg <= fcount_reg + 1'b1;
            end
            if (ctl.plen_from_len)
            begin
                plen_reg <= req_reg.seg_length;
            end
            else if (ctl.plen_from_slot)
            begin
                plen_reg <= slot_rd_reg.len;
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.command       = req_reg.command;
        stat.id_live       = (id32 < 32'(SEGMENT_SLOTS)) && slot_rd_reg.used;
        stat.off_in_seg    = {1'b0, req_reg.word_offset} < slot_rd_reg.len;
        stat.off_in_prog   = {1'b0, req_reg.word_offset} < plen_reg;
        stat.full          = 32'(live_reg) == 32'(SEGMENT_SLOTS);
        stat.too_long      = 32'(req_reg.seg_length) > 32'(SEGMENT_WORDS);
        stat.len_zero      = req_reg.seg_length == 9'd0;
        stat.slen_zero     = slot_rd_reg.len == 9'd0;
        stat.ctr_last_len  = 32'(ctr_plus) == 32'(req_reg.seg_length);
        stat.ctr_last_slen = 32'(ctr_plus) == 32'(slot_rd_reg.len);
        stat.ctr_last_slot = ctr32 == 32'(SEGMENT_SLOTS - 1);
        stat.out_free      = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

`default_nettype wire

@@ design/segment_id_allocator_memory.sv @@
// Each command passes through lookup, execute and response states; map and program_alloc
// add a fill state that clears one word at a time, and load_program adds a read and
// a write state per word copied (segment read, then program write).
// One command is in flight at a time; the next is taken as soon as the response
// is registered, even while it waits to be taken. After reset the slot table is
// swept with cmd_ready low.
`default_nettype none

module segment_id_allocator_memory #(
    parameter int SEGMENT_SLOTS = 64,
    parameter int SEGMENT_WORDS = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire sia_pkg::req_t cmd_data,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output sia_pkg::rsp_t      rsp_data
);

    sia_pkg::dp_cmd_t  ctl;
    sia_pkg::dp_stat_t stat;

    sia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    sia_datapath #(
        .SEGMENT_SLOTS (SEGMENT_SLOTS),
        .SEGMENT_WORDS (SEGMENT_WORDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .ctl       (ctl),
        .stat      (stat)
    );

endmodule

`default_nettype wire

@@ design/sia_checker.sv @@
// Port-level checks for segment_id_allocator_memory, bound to the top level.
// Depends on sia_pkg.
`default_nettype none

module sia_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          cmd_valid,
    input wire logic          cmd_ready,
    input wire sia_pkg::req_t cmd_data,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire sia_pkg::rsp_t rsp_data
);

    // Only one command is worked on at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is in flight");

    // A response never follows its command beat in the very next cycle.
    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !$rose(rsp_valid))
        else $error("response appeared too early");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

    // A failed command grants nothing and reads nothing.
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != sia_pkg::ST_OK
            |-> rsp_data.granted_id == 6'd0 && rsp_data.read_word == 32'd0)
        else $error("error response carries data");

    logic unused_ok;
    assign unused_ok = ^cmd_data;

endmodule

bind segment_id_allocator_memory sia_checker u_sia_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for segment_id_allocator_memory: drives command beats,
// predicts every response with a behavioural model of the segment memory and checks it.
// Depends on sia_pkg and the RTL of segment_id_allocator_memory.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    localparam int WORDS = 256;
    localparam int WATCHDOG_LIMIT = 200000;

    // Behavioural model of the segment memory with a queue of predicted responses.
    class seg_mem_scoreboard;
        logic [31:0] seg_words[SLOTS][WORDS];
        logic [8:0]  seg_len[SLOTS];
        bit          in_use[SLOTS];
        logic [5:0]  free_ids[SLOTS];
        int          free_cnt;
        int          live_cnt;
        logic [31:0] prog_words[WORDS];
        logic [8:0]  prog_len;
        sia_pkg::rsp_t pending[$];
        int          errors;
        int          checked;

        function void clear();
            foreach (seg_len[i]) begin
                seg_len[i] = '0;
                in_use[i] = 1'b0;
            end
            free_cnt = 0;
            live_cnt = 0;
            prog_len = '0;
            pending.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void note_command(sia_pkg::req_t r);
            sia_pkg::rsp_t e;
            int nid;
            e = '0;
            e.status = sia_pkg::ST_OK;
            case (sia_pkg::cmd_e'(r.command))
                sia_pkg::CMD_MAP: begin
                    if (live_cnt >= SLOTS) e.status = sia_pkg::ST_FULL;
                    else if (r.seg_length > WORDS) e.status = sia_pkg::ST_TOO_LONG;
                    else begin
                        if (free_cnt == 0) nid = live_cnt;
                        else begin
                            free_cnt--;
                            nid = free_ids[free_cnt];
                        end
                        for (int w = 0; w < WORDS; w++) seg_words[nid][w] = '0;
                        seg_len[nid] = r.seg_length;
                        in_use[nid] = 1'b1;
                        live_cnt++;
                        e.granted_id = nid[5:0];
                    end
                end
                sia_pkg::CMD_UNMAP: begin
                    if (!in_use[r.segment_id]) e.status = sia_pkg::ST_UNMAPPED;
                    else begin
                        in_use[r.segment_id] = 1'b0;
                        seg_len[r.segment_id] = '0;
                        free_ids[free_cnt] = r.segment_id;
                        free_cnt++;
                        live_cnt--;
                    end
                end
                sia_pkg::CMD_LOAD, sia_pkg::CMD_STORE: begin
                    if (!in_use[r.segment_id]) e.status = sia_pkg::ST_UNMAPPED;
                    else if (r.word_offset >= seg_len[r.segment_id])
                        e.status = sia_pkg::ST_RANGE;
                    else if (sia_pkg::cmd_e'(r.command) == sia_pkg::CMD_LOAD)
                        e.read_word = seg_words[r.segment_id][r.word_offset];
                    else seg_words[r.segment_id][r.word_offset] = r.write_word;
                end
                sia_pkg::CMD_LOAD_PROG: begin
                    if (!in_use[r.segment_id]) e.status = sia_pkg::ST_UNMAPPED;
                    else begin
                        for (int w = 0; w < seg_len[r.segment_id]; w++)
                            prog_words[w] = seg_words[r.segment_id][w];
                        prog_len = seg_len[r.segment_id];
                    end
                end
                sia_pkg::CMD_PROG_ALLOC: begin
                    if (r.seg_length > WORDS) e.status = sia_pkg::ST_TOO_LONG;
                    else begin
                        for (int w = 0; w < WORDS; w++) prog_words[w] = '0;
                        prog_len = r.seg_length;
                    end
                end
                sia_pkg::CMD_PROG_WRITE: begin
                    if (r.word_offset >= prog_len) e.status = sia_pkg::ST_RANGE;
                    else prog_words[r.word_offset] = r.write_word;
                end
                default: begin
                    if (r.word_offset >= prog_len) e.status = sia_pkg::ST_RANGE;
                    else e.read_word = prog_words[r.word_offset];
                end
            endcase
            e.program_length = prog_len;
            pending.push_back(e);
        endfunction

        function void check_response(sia_pkg::rsp_t a);
            sia_pkg::rsp_t e;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: response with none expected, actual %p", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
                errors++;
            end
            if (a.granted_id !== e.granted_id) begin
                $display("%0t: granted_id expected %0d actual %0d", $time,
                         e.granted_id, a.granted_id);
                errors++;
            end
            if (a.read_word !== e.read_word) begin
                $display("%0t: read_word expected %h actual %h", $time,
                         e.read_word, a.read_word);
                errors++;
            end
            if (a.program_length !== e.program_length) begin
                $display("%0t: program_length expected %0d actual %0d", $time,
                         e.program_length, a.program_length);
                errors++;
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  cmd_valid;
    logic  cmd_ready;
    sia_pkg::req_t cmd_data;
    logic  rsp_valid;
    logic  rsp_ready;
    sia_pkg::rsp_t rsp_data;

    seg_mem_scoreboard sb;
    int    sent;
    int    idle_cycles;
    bit    stim_done;
    bit    quiet_rsp;
    logic [5:0] mapped_ids[$];

    segment_id_allocator_memory dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, with the odd long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Valid drops only when a gap follows, so a back-to-back beat keeps it high.
    task automatic send_command(sia_pkg::req_t r);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data <= r;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        sb.note_command(r);
        sent++;
    endtask

    function automatic sia_pkg::req_t make_cmd(sia_pkg::cmd_e c, int id, int off, int len,
                                               logic [31:0] wd);
        sia_pkg::req_t r;
        r.command = c;
        r.segment_id = id[5:0];
        r.word_offset = off[7:0];
        r.seg_length = len[8:0];
        r.write_word = wd;
        return r;
    endfunction

    function automatic sia_pkg::req_t random_cmd();
        int p;
        int id;
        int len;
        logic [63:0] raw;
        p = $urandom_range(0, 99);
        if (mapped_ids.size() > 0 && $urandom_range(0, 9) < 8)
            id = mapped_ids[$urandom_range(0, mapped_ids.size() - 1)];
        else id = $urandom_range(0, 63);
        // Lengths mostly short so that clearing and copying stay quick.
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
        if (p < 12) return make_cmd(sia_pkg::CMD_MAP, 0, 0, len, $urandom());
        if (p < 20) return make_cmd(sia_pkg::CMD_UNMAP, id, 0, 0, $urandom());
        if (p < 40)
            return make_cmd(sia_pkg::CMD_LOAD, id, $urandom_range(0, 14), 0, $urandom());
        if (p < 62)
            return make_cmd(sia_pkg::CMD_STORE, id, $urandom_range(0, 14), 0, $urandom());
        if (p < 67) return make_cmd(sia_pkg::CMD_LOAD_PROG, id, 0, 0, $urandom());
        if (p < 71) return make_cmd(sia_pkg::CMD_PROG_ALLOC, 0, 0, len, $urandom());
        if (p < 86)
            return make_cmd(sia_pkg::CMD_PROG_WRITE, 0, $urandom_range(0, 14), 0,
                            $urandom());
        if (p < 98)
            return make_cmd(sia_pkg::CMD_PROG_READ, 0, $urandom_range(0, 14), 0,
                            $urandom());
        // Noise: any field value at all.
        raw = {$urandom(), $urandom()};
        return sia_pkg::req_t'(raw[$bits(sia_pkg::req_t)-1:0]);
    endfunction

    // Keeps a list of live IDs so random traffic mostly hits mapped segments.
    task automatic send_tracked(sia_pkg::req_t r);
        send_command(r);
        mapped_ids.delete();
        for (int i = 0; i < SLOTS; i++)
            if (sb.in_use[i]) mapped_ids.push_back(i[5:0]);
    endtask

    // Response side: random stalls, with quiet stretches where it is always ready.
    initial
    begin
        int g;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = quiet_rsp ? 0 : gap_len();
            if (g > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready) sb.check_response(rsp_data);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        sb.clear();
        sent = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        quiet_rsp = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: field extremes, every command and each error case.
        send_tracked(make_cmd(sia_pkg::CMD_LOAD, 0, 0, 0, '0));
        send_tracked(make_cmd(sia_pkg::CMD_PROG_READ, 0, 0, 0, '0));
        send_tracked(make_cmd(sia_pkg::CMD_MAP, 0, 0, 257, '0));
        send_tracked(make_cmd(sia_pkg::CMD_MAP, 0, 0, 511, '0));
        send_tracked(make_cmd(sia_pkg::CMD_MAP, 0, 0, 256, '0));
        send_tracked(make_cmd(sia_pkg::CMD_MAP, 63, 255, 0, '1));
        send_tracked(make_cmd(sia_pkg::CMD_STORE, 0, 255, 0, 32'hFFFF_FFFF));
        send_tracked(make_cmd(sia_pkg::CMD_LOAD, 0, 255, 0, '0));
        send_tracked(make_cmd(sia_pkg::CMD_LOAD, 0, 7, 0, '0));
        send_tracked(make_cmd(sia_pkg::CMD_STORE, 1, 0, 0, '1));
        send_tracked(make_cmd(sia_pkg::CMD_LOAD_PROG, 0, 0, 0, '0));
        send_tracked(make_cmd(sia_pkg::CMD_PROG_READ, 0, 255, 0, '0));
        send_tracked(make_cmd(sia_pkg::CMD_PROG_WRITE, 0, 0, 0, 32'h5A5A_A5A5));
        send_tracked(make_cmd(sia_pkg::CMD_PROG_ALLOC, 0, 0, 257, '0));
        send_tracked(make_cmd(sia_pkg::CMD_PROG_ALLOC, 0, 0, 3, '0));
        send_tracked(make_cmd(sia_pkg::CMD_PROG_WRITE, 0, 3, 0, '1));
        send_tracked(make_cmd(sia_pkg::CMD_LOAD_PROG, 1, 0, 0, '0));
        send_tracked(make_cmd(sia_pkg::CMD_UNMAP, 0, 0, 0, '0));
        send_tracked(make_cmd(sia_pkg::CMD_UNMAP, 0, 0, 0, '0));
        send_tracked(make_cmd(sia_pkg::CMD_UNMAP, 63, 0, 0, '0));
        send_tracked(make_cmd(sia_pkg::CMD_MAP, 0, 0, 2, '0));
        // Fill the table and try one more map.
        while (sb.live_cnt < SLOTS) send_tracked(make_cmd(sia_pkg::CMD_MAP, 0, 0, 1, '0));
        send_tracked(make_cmd(sia_pkg::CMD_MAP, 0, 0, 0, '0));
        // Free a batch so reuse comes off the stack last-freed-first.
        for (int i = 60; i >= 0; i -= 3)
            send_tracked(make_cmd(sia_pkg::CMD_UNMAP, i, 0, 0, '0));

        for (int n = 0; n < 1000; n++)
        begin
            if (n % 200 == 100) quiet_rsp = 1'b1;
            if (n % 200 == 150) quiet_rsp = 1'b0;
            send_tracked(random_cmd());
        end
        cmd_valid <= 1'b0;
        stim_done = 1'b1;

        while (sb.pending.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d commands and checked %0d responses over all eight commands,",
                 sent, sb.checked);
        $display("including full table, slot reuse, range and length errors.");
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
